// ===== rtl/czsg_pkg.sv =====
package czsg_pkg;

  localparam int POS_BITS_DEF = 16;

  localparam logic [6:0] XY_DELAY_CAP  = 7'd99;
  localparam logic [2:0] Z_MOVE_DELAY  = 3'd3;
  localparam logic [2:0] Z_RESET_DELAY = 3'd6;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_PLAN = 2'd1,
    REQ_ZSET = 2'd2
  } req_e;

  localparam logic [2:0] REG_X_MIN = 3'd0;
  localparam logic [2:0] REG_X_MAX = 3'd1;
  localparam logic [2:0] REG_Y_MIN = 3'd2;
  localparam logic [2:0] REG_Y_MAX = 3'd3;
  localparam logic [2:0] REG_Z_MIN = 3'd4;
  localparam logic [2:0] REG_Z_MAX = 3'd5;

  // input beat payload, lowest field last
  typedef struct packed {
    logic               pad;
    logic signed [15:0] z_goal;
    logic [6:0]         delay_ticks;
    logic signed [7:0]  vel_y;
    logic signed [7:0]  vel_x;
  } in_t;

  // result beat payload, lowest field last
  typedef struct packed {
    logic [1:0]         pad;
    logic               z_busy;
    logic [14:0]        z_position;
    logic signed [15:0] y_position;
    logic signed [15:0] x_position;
    logic               dir_z;
    logic               step_z;
    logic               dir_b;
    logic               step_b;
    logic               dir_a;
    logic               step_a;
  } res_t;

endpackage

// ===== rtl/corexy_z_step_generator.sv =====
// An accepted input beat is registered in s1, and its result beat in res_q.
// Throughput: one beat per cycle unless m_axis_tready stalls the output; all work
// for a beat is done between them, with the axis state updated in the same cycle.
// Reset (rst_ni low, asynchronous): pipeline empty, motors stopped, positions zero,
// window registers at their defaults, z step delay at six ticks.
module corexy_z_step_generator #(
  parameter int POS_BITS = czsg_pkg::POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vel_x, vel_y, delay_ticks, z_goal, zero pad
  input  logic [39:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // step_a, dir_a, step_b, dir_b, step_z, dir_z, x_position, y_position,
  // z_position, z_busy, zero pad
  output logic [55:0] m_axis_tdata
);

  localparam int CW = ((POS_BITS > 16) ? POS_BITS : 16) + 1;

  // config registers
  logic signed [15:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic [14:0]        z_min_q, z_max_q;

  // pipeline
  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_req_q;
  czsg_pkg::in_t     s1_data_q;
  logic              m_valid_q, m_valid_d;
  czsg_pkg::res_t    res_q, res_d;
  logic              out_free, adv, fire_in;

  // axis state
  logic [6:0]                xy_tick_q, xy_tick_d;
  logic [6:0]                xy_reload_q, xy_reload_d;
  logic [7:0]                rate_a_q, rate_a_d, rate_b_q, rate_b_d;
  logic signed [1:0]         sign_a_q, sign_a_d, sign_b_q, sign_b_d;
  logic [9:0]                err_a_q, err_a_d, err_b_q, err_b_d;
  logic signed [POS_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic [15:0]               z_rem_q, z_rem_d;
  logic                      z_dir_q, z_dir_d;
  logic [2:0]                z_tick_q, z_tick_d;
  logic [2:0]                z_delay_q, z_delay_d;
  logic                      z_en_q, z_en_d;

  // ---------------------------------------------------------------- APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:2])
      czsg_pkg::REG_X_MIN: prdata = {16'd0, x_min_q};
      czsg_pkg::REG_X_MAX: prdata = {16'd0, x_max_q};
      czsg_pkg::REG_Y_MIN: prdata = {16'd0, y_min_q};
      czsg_pkg::REG_Y_MAX: prdata = {16'd0, y_max_q};
      czsg_pkg::REG_Z_MIN: prdata = {17'd0, z_min_q};
      czsg_pkg::REG_Z_MAX: prdata = {17'd0, z_max_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= 16'sd0;
      x_max_q <= 16'sd32767;
      y_min_q <= 16'sd0;
      y_max_q <= 16'sd32767;
      z_min_q <= 15'd0;
      z_max_q <= 15'h7FFF;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        czsg_pkg::REG_X_MIN: x_min_q <= pwdata[15:0];
        czsg_pkg::REG_X_MAX: x_max_q <= pwdata[15:0];
        czsg_pkg::REG_Y_MIN: y_min_q <= pwdata[15:0];
        czsg_pkg::REG_Y_MAX: y_max_q <= pwdata[15:0];
        czsg_pkg::REG_Z_MIN: z_min_q <= pwdata[14:0];
        czsg_pkg::REG_Z_MAX: z_max_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign out_free      = !m_valid_q || m_axis_tready;
  assign adv           = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign fire_in       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fire_in) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (adv) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- xy step event
  logic                  first_is_a, f_ok, s_ok, second_go, xy_event;
  logic signed [1:0]     f_sx, f_sy, s_sx, s_sy;
  logic signed [CW-1:0]  xlo, xhi, ylo, yhi;
  logic signed [CW-1:0]  px0, py0, f_nx, f_ny, px1, py1, s_nx, s_ny, px2, py2;
  logic [9:0]            e0, e1, e2;
  logic [7:0]            r_small, r_big;

  always_comb begin
    first_is_a = rate_a_q >= rate_b_q;
    f_sx = first_is_a ? sign_a_q : sign_b_q;
    f_sy = first_is_a ? sign_a_q : -sign_b_q;
    s_sx = first_is_a ? sign_b_q : sign_a_q;
    s_sy = first_is_a ? -sign_b_q : sign_a_q;
    xlo = CW'(x_min_q);
    xhi = CW'(x_max_q);
    ylo = CW'(y_min_q);
    yhi = CW'(y_max_q);

    px0  = CW'(pos_x_q);
    py0  = CW'(pos_y_q);
    f_nx = px0 + CW'(f_sx);
    f_ny = py0 + CW'(f_sy);
    f_ok = (f_sx != 2'sd0) && (f_nx >= xlo) && (f_nx <= xhi) &&
           (f_ny >= ylo) && (f_ny <= yhi);
    px1  = f_ok ? CW'($signed(f_nx[POS_BITS-1:0])) : px0;
    py1  = f_ok ? CW'($signed(f_ny[POS_BITS-1:0])) : py0;

    e0        = first_is_a ? err_a_q : err_b_q;
    r_small   = first_is_a ? rate_b_q : rate_a_q;
    r_big     = first_is_a ? rate_a_q : rate_b_q;
    e1        = e0 + {2'b00, r_small};
    second_go = e1 >= {2'b00, r_big};
    e2        = second_go ? (e1 - {2'b00, r_big}) : e1;

    s_nx = px1 + CW'(s_sx);
    s_ny = py1 + CW'(s_sy);
    s_ok = second_go && (s_sx != 2'sd0) && (s_nx >= xlo) && (s_nx <= xhi) &&
           (s_ny >= ylo) && (s_ny <= yhi);
    px2  = s_ok ? CW'($signed(s_nx[POS_BITS-1:0])) : px1;
    py2  = s_ok ? CW'($signed(s_ny[POS_BITS-1:0])) : py1;

    xy_event = xy_tick_q <= 7'd1;
  end

  // ---------------------------------------------------------------- plan and z set
  logic signed [8:0]    va, vb;
  logic [8:0]           ma, mb;
  logic [14:0]          zt;
  logic signed [CW-1:0] zdelta, zabs;
  logic [2:0]           zcnt;

  always_comb begin
    va = 9'(s1_data_q.vel_x) + 9'(s1_data_q.vel_y);
    vb = 9'(s1_data_q.vel_x) - 9'(s1_data_q.vel_y);
    ma = va[8] ? 9'(-va) : 9'(va);
    mb = vb[8] ? 9'(-vb) : 9'(vb);

    zt = s1_data_q.z_goal[14:0];
    if (zt < z_min_q) begin
      zt = z_min_q;
    end else if (zt > z_max_q) begin
      zt = z_max_q;
    end
    zdelta = CW'($signed({1'b0, zt})) - CW'(pos_z_q);
    zabs   = zdelta[CW-1] ? -zdelta : zdelta;

    zcnt = (z_tick_q != 3'd0) ? (z_tick_q - 3'd1) : 3'd0;
  end

  // ---------------------------------------------------------------- next state
  logic step_a, step_b, step_z;
  logic signed [CW-1:0] ox, oy, oz;

  always_comb begin
    xy_tick_d   = xy_tick_q;
    xy_reload_d = xy_reload_q;
    rate_a_d    = rate_a_q;
    rate_b_d    = rate_b_q;
    sign_a_d    = sign_a_q;
    sign_b_d    = sign_b_q;
    err_a_d     = err_a_q;
    err_b_d     = err_b_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    pos_z_d     = pos_z_q;
    z_rem_d     = z_rem_q;
    z_dir_d     = z_dir_q;
    z_tick_d    = z_tick_q;
    z_delay_d   = z_delay_q;
    z_en_d      = z_en_q;
    step_a      = 1'b0;
    step_b      = 1'b0;
    step_z      = 1'b0;

    case (s1_req_q)
      czsg_pkg::REQ_TICK: begin
        if (xy_event) begin
          step_a    = first_is_a ? f_ok : s_ok;
          step_b    = first_is_a ? s_ok : f_ok;
          pos_x_d   = px2[POS_BITS-1:0];
          pos_y_d   = py2[POS_BITS-1:0];
          xy_tick_d = xy_reload_q;
          if (first_is_a) begin
            err_a_d = e2;
          end else begin
            err_b_d = e2;
          end
        end else begin
          xy_tick_d = xy_tick_q - 7'd1;
        end
        z_tick_d = zcnt;
        if (zcnt == 3'd0 && z_en_q) begin
          if (z_rem_q == 16'd0) begin
            z_en_d = 1'b0;
          end else begin
            step_z   = 1'b1;
            pos_z_d  = pos_z_q + (z_dir_q ? POS_BITS'(1) : {POS_BITS{1'b1}});
            z_rem_d  = z_rem_q - 16'd1;
            z_tick_d = z_delay_q;
          end
        end
      end
      czsg_pkg::REQ_PLAN: begin
        if (s1_data_q.vel_x == 8'sd0 && s1_data_q.vel_y == 8'sd0) begin
          rate_a_d = 8'd0;
          rate_b_d = 8'd0;
          sign_a_d = 2'sd0;
          sign_b_d = 2'sd0;
        end else begin
          sign_a_d    = va[8] ? -2'sd1 : 2'sd1;
          sign_b_d    = vb[8] ? -2'sd1 : 2'sd1;
          rate_a_d    = ma[8] ? 8'hFF : ma[7:0];
          rate_b_d    = mb[8] ? 8'hFF : mb[7:0];
          err_a_d     = 10'd0;
          err_b_d     = 10'd0;
          xy_reload_d = (s1_data_q.delay_ticks > czsg_pkg::XY_DELAY_CAP) ?
                        czsg_pkg::XY_DELAY_CAP : s1_data_q.delay_ticks;
        end
      end
      czsg_pkg::REQ_ZSET: begin
        if (!z_en_q && !s1_data_q.z_goal[15] && zdelta != '0) begin
          z_dir_d   = !zdelta[CW-1];
          z_rem_d   = zabs[15:0];
          z_delay_d = czsg_pkg::Z_MOVE_DELAY;
          z_en_d    = 1'b1;
        end
      end
      default: ;
    endcase

    ox = CW'(pos_x_d);
    oy = CW'(pos_y_d);
    oz = CW'(pos_z_d);
    res_d.pad        = 2'b00;
    res_d.z_busy     = z_en_d;
    res_d.z_position = oz[14:0];
    res_d.y_position = oy[15:0];
    res_d.x_position = ox[15:0];
    res_d.dir_z      = z_dir_d;
    res_d.step_z     = step_z;
    res_d.dir_b      = sign_b_d == 2'sd1;
    res_d.step_b     = step_b;
    res_d.dir_a      = sign_a_d == 2'sd1;
    res_d.step_a     = step_a;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      xy_tick_q   <= 7'd0;
      xy_reload_q <= 7'd0;
      rate_a_q    <= 8'd0;
      rate_b_q    <= 8'd0;
      sign_a_q    <= 2'sd0;
      sign_b_q    <= 2'sd0;
      err_a_q     <= 10'd0;
      err_b_q     <= 10'd0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      z_rem_q     <= 16'd0;
      z_dir_q     <= 1'b0;
      z_tick_q    <= 3'd0;
      z_delay_q   <= czsg_pkg::Z_RESET_DELAY;
      z_en_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      if (adv) begin
        xy_tick_q   <= xy_tick_d;
        xy_reload_q <= xy_reload_d;
        rate_a_q    <= rate_a_d;
        rate_b_q    <= rate_b_d;
        sign_a_q    <= sign_a_d;
        sign_b_q    <= sign_b_d;
        err_a_q     <= err_a_d;
        err_b_q     <= err_b_d;
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        pos_z_q     <= pos_z_d;
        z_rem_q     <= z_rem_d;
        z_dir_q     <= z_dir_d;
        z_tick_q    <= z_tick_d;
        z_delay_q   <= z_delay_d;
        z_en_q      <= z_en_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      s1_req_q  <= s_axis_tuser;
      s1_data_q <= s_axis_tdata;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_zstep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.step_z) |-> res_q.z_busy)
    else $error("z step reported without a z move in progress");

  a_stop_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sign_a_q == 2'sd0) == (sign_b_q == 2'sd0))
    else $error("only one motor stopped");

  a_stop_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sign_a_q == 2'sd0) |-> (rate_a_q == 8'd0 && rate_b_q == 8'd0))
    else $error("stopped motor with nonzero rate");

  a_reload_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xy_tick_q <= czsg_pkg::XY_DELAY_CAP) && (xy_reload_q <= czsg_pkg::XY_DELAY_CAP))
    else $error("xy tick counter above cap");

  a_cmd_nostep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_req_q != czsg_pkg::REQ_TICK) |=>
      (!res_q.step_a && !res_q.step_b && !res_q.step_z))
    else $error("step pulse on a command beat");
`endif

endmodule
